// File: src/message_crc32_check_defines.svh
// assertion macros for the crc-32 message checker
`ifndef MESSAGE_CRC32_CHECK_DEFINES_SVH
`define MESSAGE_CRC32_CHECK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mcc_pkg.sv
// types, constants and crc table function for the crc-32 message checker
`default_nettype none
package mcc_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [15:0] CRC_HEAD_END  = 16'd8;
    localparam logic [15:0] CRC_FIELD_END = 16'd12;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_LENGTH = 2'd1;

    localparam logic [7:0]  HLEN_RESET = 8'd12;
    localparam logic [15:0] MAXL_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_mcc_in;

    typedef struct packed {
        logic [31:0] crc_value;
        logic        size_valid;
        logic        crc_match;
    } t_mcc_out;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       covered;
        logic       cap_en;
        logic [1:0] cap_lane;
        logic       last;
        logic       size_valid;
    } t_mcc_op;

    function automatic logic [31:0] crc_table(input logic [7:0] idx);
        logic [31:0] v;
        v = {24'b0, idx};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/mcc_front.sv
// front end: byte position tracking, coverage and size classification
`default_nettype none
module mcc_front import mcc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_mcc_in     i_item,
    input  wire logic        i_q_full,
    input  wire logic [7:0]  i_header_length,
    input  wire logic [15:0] i_max_message_length,
    output logic             o_op_valid,
    output t_mcc_op          o_op
);

    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [16:0] w_length;
    logic        w_accept;

    assign w_accept = i_push && !i_q_full;
    assign w_length = {1'b0, r_count} + 17'd1;

    always_comb begin
        o_op.data_byte  = i_item.data_byte;
        o_op.covered    = (r_count < CRC_HEAD_END) || (r_count >= {8'b0, i_header_length});
        o_op.cap_en     = (r_count >= CRC_HEAD_END) && (r_count < CRC_FIELD_END);
        o_op.cap_lane   = r_count[1:0];
        o_op.last       = i_item.end_of_message;
        o_op.size_valid = (w_length >= {9'b0, i_header_length})
                       && (w_length <= {1'b0, i_max_message_length});
    end

    assign o_op_valid = w_accept;

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (i_item.end_of_message) begin
                n_count = '0;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: src/mcc_fifo.sv
// short queue of classified bytes between front and back
`default_nettype none
module mcc_fifo import mcc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_mcc_op i_wdata,
    input  wire logic i_rd,
    output logic      o_full,
    output logic      o_valid,
    output t_mcc_op   o_rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_mcc_op          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_wr) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_rd) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: src/mcc_back.sv
// back end: running crc, received crc capture and result register
`default_nettype none
module mcc_back import mcc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_op_valid,
    input  wire t_mcc_op i_op,
    input  wire logic i_pop,
    output logic      o_op_rd,
    output logic      o_empty,
    output t_mcc_out  o_result
);

    logic [31:0] r_crc;
    logic [31:0] r_rcv;
    logic        r_out_valid;
    t_mcc_out    r_out;
    logic [31:0] n_crc;
    logic [31:0] n_rcv;
    logic        n_out_valid;
    t_mcc_out    n_out;
    logic [31:0] w_crc_upd;
    logic [31:0] w_rcv_upd;
    logic [31:0] w_crc_fin;
    logic        w_out_take;

    assign w_out_take = r_out_valid && i_pop;
    assign o_op_rd    = i_op_valid && (!i_op.last || !r_out_valid || i_pop);
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        w_crc_upd = i_op.covered
                  ? (crc_table(r_crc[7:0] ^ i_op.data_byte) ^ (r_crc >> 8)) : r_crc;
        w_rcv_upd = r_rcv;
        if (i_op.cap_en) begin
            case (i_op.cap_lane)
                2'd0:    w_rcv_upd = r_rcv | {24'b0, i_op.data_byte};
                2'd1:    w_rcv_upd = r_rcv | {16'b0, i_op.data_byte, 8'b0};
                2'd2:    w_rcv_upd = r_rcv | {8'b0, i_op.data_byte, 16'b0};
                default: w_rcv_upd = r_rcv | {i_op.data_byte, 24'b0};
            endcase
        end
        w_crc_fin = i_op.size_valid ? ~w_crc_upd : 32'b0;
    end

    always_comb begin
        n_crc       = r_crc;
        n_rcv       = r_rcv;
        n_out       = r_out;
        n_out_valid = r_out_valid && !w_out_take;
        if (o_op_rd) begin
            if (i_op.last) begin
                n_crc            = CRC_INIT;
                n_rcv            = '0;
                n_out_valid      = 1'b1;
                n_out.crc_value  = w_crc_fin;
                n_out.size_valid = i_op.size_valid;
                n_out.crc_match  = i_op.size_valid && (w_rcv_upd == w_crc_fin);
            end else begin
                n_crc = w_crc_upd;
                n_rcv = w_rcv_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_rcv       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_rcv       <= n_rcv;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// File: src/message_crc32_check.sv
// top level of the crc-32 message checker
// input side is a queue: put a byte and its end flag on i_item with i_push;
// the transaction completes on a clock edge with i_push high and o_full low.
// result side is a single result register: while o_empty is low the result
// sits on o_result; it is taken on a clock edge with i_pop high.
// one result comes out for each byte flagged as end of message.
// configuration: i_cfg_valid with i_cfg_index and i_cfg_data, o_cfg_ready is
// always high; index 0 is the header length, index 1 the maximum length.
// throughput is one byte per cycle while a pending result does not hold a
// final byte in the queue; the byte-wise crc table update in the back end is
// the loop that sets it. when the queue is empty, o_empty falls once the last
// byte has passed front to queue and then queue to result register.
// when the receiver stalls the result register holds; further bytes keep
// flowing into the queue until it fills, then o_full rises.
// synchronous reset clears counters, crc state, queue and result valid flag, and
// restores the configuration defaults.
`default_nettype none
`include "message_crc32_check_defines.svh"
module message_crc32_check import mcc_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire t_mcc_in              i_item,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output t_mcc_out                  o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    logic [7:0]  r_header_length;
    logic [15:0] r_max_message_length;
    logic        w_q_full;
    logic        w_front_valid;
    t_mcc_op     w_front_op;
    logic        w_q_valid;
    t_mcc_op     w_q_op;
    logic        w_q_rd;

    assign o_cfg_ready = 1'b1;
    assign o_full      = w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length      <= HLEN_RESET;
            r_max_message_length <= MAXL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEADER_LENGTH:      r_header_length      <= i_cfg_data[7:0];
                CFG_MAX_MESSAGE_LENGTH: r_max_message_length <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mcc_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_push               (i_push),
        .i_item               (i_item),
        .i_q_full             (w_q_full),
        .i_header_length      (r_header_length),
        .i_max_message_length (r_max_message_length),
        .o_op_valid           (w_front_valid),
        .o_op                 (w_front_op)
    );

    mcc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_front_valid),
        .i_wdata (w_front_op),
        .i_rd    (w_q_rd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_rdata (w_q_op)
    );

    mcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_q_valid),
        .i_op       (w_q_op),
        .i_pop      (i_pop),
        .o_op_rd    (w_q_rd),
        .o_empty    (o_empty),
        .o_result   (o_result)
    );

    `MCC_ASSERT_NOW(a_match_needs_size, !o_empty && o_result.crc_match, o_result.size_valid, "crc match without valid size")
    `MCC_ASSERT_NOW(a_bad_size_zero_crc, !o_empty && !o_result.size_valid, o_result.crc_value == 32'b0, "nonzero crc on bad size")
    `MCC_ASSERT_NOW(a_full_has_data, w_q_full, w_q_valid, "queue full but no entry readable")
    `MCC_ASSERT_NEXT(a_rd_drains, w_q_valid && !w_q_op.last && !w_front_valid && !w_q_full, !w_q_full, "non-final byte not drained")

endmodule
`default_nettype wire
